/* hw/rtl/mffu_pkg.sv */
// Shared types, constants and register codes for the motor feedback unwrap block.
`timescale 1ns / 1ps
package mffu_pkg;

	localparam int MOTOR_COUNT_DEF  = 2;
	localparam int ENCODER_BITS_DEF = 14;
	localparam int ACCUM_BITS_DEF   = 40;

	localparam int ID_BITS       = 11;
	localparam int LEN_BITS      = 4;
	localparam int BYTE_BITS     = 8;
	localparam int SPEED_BITS    = 16;
	localparam int ENC_RAW_BITS  = 16;
	localparam int ENC_MAX_BITS  = 24;
	localparam int ACC_MAX_BITS  = 48;
	localparam int PSCALE_BITS   = 48;
	localparam int VSCALE_BITS   = 32;
	localparam int VEL_BITS      = 32;
	localparam int POS_BITS      = 48;
	localparam int APB_ADDR_BITS = 6;
	localparam int APB_DATA_BITS = 64;
	localparam int IN_DATA_BITS  = 56;
	localparam int IN_USER_BITS  = 2;
	localparam int OUT_DATA_BITS = 80;

	localparam logic [BYTE_BITS-1:0] REPLY_STATUS = 8'h9C;
	localparam logic [LEN_BITS-1:0]  MIN_LENGTH   = 4'd8;

	localparam logic [VEL_BITS-1:0] VEL_MAX = {1'b0, {(VEL_BITS-1){1'b1}}};
	localparam logic [VEL_BITS-1:0] VEL_MIN = {1'b1, {(VEL_BITS-1){1'b0}}};
	localparam logic [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
	localparam logic [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

	localparam logic [PSCALE_BITS-1:0] POS_SCALE_RST = 48'd6749;
	localparam logic [VSCALE_BITS-1:0] VEL_SCALE_RST = 32'd292818;

	typedef enum logic [2:0] {
		REG_LEFT_ID   = 3'd0,
		REG_RIGHT_ID  = 3'd1,
		REG_LEFT_REV  = 3'd2,
		REG_RIGHT_REV = 3'd3,
		REG_POS_SCALE = 3'd4,
		REG_VEL_SCALE = 3'd5
	} reg_idx_t;

	typedef enum logic {
		KIND_FRAME   = 1'b0,
		KIND_RESTART = 1'b1
	} item_kind_t;

	// One input word after unpacking.
	typedef struct packed {
		item_kind_t                kind;
		logic                      motor;
		logic [ID_BITS-1:0]        frame_id;
		logic [LEN_BITS-1:0]       frame_length;
		logic [BYTE_BITS-1:0]      reply_code;
		logic [SPEED_BITS-1:0]     speed;
		logic [ENC_RAW_BITS-1:0]   encoder;
	} mffu_item_t;

	// Frame match settings handed to the tracker.
	typedef struct packed {
		logic [ID_BITS-1:0] left_id;
		logic [ID_BITS-1:0] right_id;
		logic               left_rev;
		logic               right_rev;
	} mffu_match_t;

	// Tracked sample handed from the tracker to the scaler.
	typedef struct packed {
		logic                           motor;
		logic                           rev;
		logic [SPEED_BITS-1:0]          speed;
		logic signed [ACC_MAX_BITS-1:0] acc;
	} mffu_sample_t;

endpackage

/* hw/rtl/mffu_track.sv */
// Frame filter and per-motor multiturn unwrap tracker.
`timescale 1ns / 1ps
module mffu_track
	import mffu_pkg::*;
#(
	parameter int MOTOR_COUNT  = MOTOR_COUNT_DEF,
	parameter int ENCODER_BITS = ENCODER_BITS_DEF,
	parameter int ACCUM_BITS   = ACCUM_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  mffu_item_t   item,
	input  mffu_match_t  match,
	input  logic         ready_s3,
	output logic         ready_s2,
	output logic         valid_s2,
	output mffu_sample_t sample_s2
);

	localparam int DW = ENCODER_BITS + 2;
	localparam int SW = ACC_MAX_BITS + 2;
	localparam int HALF_I = 1 << (ENCODER_BITS - 1);
	localparam logic signed [DW-1:0] HALF = DW'(HALF_I);
	localparam logic signed [DW-1:0] FULL = DW'(2 * HALF_I);
	localparam logic signed [SW-1:0] ONE_W = SW'(1);
	localparam logic signed [SW-1:0] AMAX = (ONE_W <<< (ACCUM_BITS - 1)) - ONE_W;
	localparam logic signed [SW-1:0] AMIN = -AMAX - ONE_W;

	logic [MOTOR_COUNT-1:0]  seen_q;
	logic [ENCODER_BITS-1:0] last_q [MOTOR_COUNT];
	logic [ACCUM_BITS-1:0]   acc_q [MOTOR_COUNT];

	logic                       motor_ok;
	logic [ID_BITS-1:0]         id_sel;
	logic                       rev_sel;
	logic                       pass;
	logic [ENC_MAX_BITS-1:0]    raw_count;
	logic [ENCODER_BITS-1:0]    count;
	logic                       cur_seen;
	logic [ENCODER_BITS-1:0]    cur_last;
	logic [ACCUM_BITS-1:0]      cur_acc;
	logic signed [DW-1:0]       delta_raw;
	logic signed [DW-1:0]       delta;
	logic signed [SW-1:0]       sum_w;
	logic signed [SW-1:0]       seed_w;
	logic signed [SW-1:0]       count_w;
	logic signed [SW-1:0]       next_w;
	logic [ACCUM_BITS-1:0]      next_acc;

	assign motor_ok = (item.motor == 1'b0) || (MOTOR_COUNT > 1);
	assign id_sel   = item.motor ? match.right_id : match.left_id;
	assign rev_sel  = item.motor ? match.right_rev : match.left_rev;
	assign pass     = (item.kind == KIND_FRAME) && motor_ok && (item.frame_id == id_sel)
		&& (item.frame_length >= MIN_LENGTH) && (item.reply_code == REPLY_STATUS);

	// Top bits of the high encoder byte fall outside the count.
	assign raw_count = {{(ENC_MAX_BITS-ENC_RAW_BITS){1'b0}}, item.encoder};
	assign count     = raw_count[ENCODER_BITS-1:0];

	always_comb begin
		cur_seen = 1'b0;
		cur_last = '0;
		cur_acc  = '0;
		for (int m = 0; m < MOTOR_COUNT; m++) begin
			if (item.motor == 1'(m)) begin
				cur_seen = seen_q[m];
				cur_last = last_q[m];
				cur_acc  = acc_q[m];
			end
		end
	end

	// Unwrap across the half-turn boundary; exactly half a turn is kept as is.
	always_comb begin
		delta_raw = $signed({2'b00, count}) - $signed({2'b00, cur_last});
		if (delta_raw > HALF) begin
			delta = delta_raw - FULL;
		end else if (delta_raw < -HALF) begin
			delta = delta_raw + FULL;
		end else begin
			delta = delta_raw;
		end
		sum_w = $signed({{(SW-ACCUM_BITS){cur_acc[ACCUM_BITS-1]}}, cur_acc})
			+ $signed({{(SW-DW){delta[DW-1]}}, delta});
		count_w = $signed({{(SW-ENCODER_BITS){1'b0}}, count});
		seed_w  = (count_w > AMAX) ? AMAX : count_w;
		if (!cur_seen) begin
			next_w = seed_w;
		end else if (sum_w > AMAX) begin
			next_w = AMAX;
		end else if (sum_w < AMIN) begin
			next_w = AMIN;
		end else begin
			next_w = sum_w;
		end
		next_acc = next_w[ACCUM_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int m = 0; m < MOTOR_COUNT; m++) begin
				last_q[m] <= '0;
				acc_q[m]  <= '0;
			end
		end else if (take) begin
			if (item.kind == KIND_RESTART) begin
				seen_q <= '0;
				for (int m = 0; m < MOTOR_COUNT; m++) begin
					last_q[m] <= '0;
					acc_q[m]  <= '0;
				end
			end else if (pass) begin
				for (int m = 0; m < MOTOR_COUNT; m++) begin
					if (item.motor == 1'(m)) begin
						seen_q[m] <= 1'b1;
						last_q[m] <= count;
						acc_q[m]  <= next_acc;
					end
				end
			end
		end
	end

	assign ready_s2 = !valid_s2 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= take && pass;
		end
	end

	always_ff @(posedge clk) begin
		if (take && pass) begin
			sample_s2.motor <= item.motor;
			sample_s2.rev   <= rev_sel;
			sample_s2.speed <= item.speed;
			sample_s2.acc   <= next_w[ACC_MAX_BITS-1:0];
		end
	end

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.kind == KIND_RESTART) |=> (seen_q == '0) && !valid_s2)
		else $error("restart did not clear tracking");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !ready_s3) |=> valid_s2 && $stable(sample_s2))
		else $error("tracked sample lost during stall");

endmodule

/* hw/rtl/mffu_scale.sv */
// Gear scaling, rounding and saturation pipeline with the output register.
`timescale 1ns / 1ps
module mffu_scale
	import mffu_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_s2,
	input  mffu_sample_t             sample_s2,
	input  logic [PSCALE_BITS-1:0]   pos_scale,
	input  logic [VSCALE_BITS-1:0]   vel_scale,
	output logic                     ready_s3,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     out_motor,
	output logic [OUT_DATA_BITS-1:0] out_data
);

	localparam int PSUM_BITS = 96;
	localparam int POS_SHIFT = 24;
	localparam int VSUM_BITS = SPEED_BITS + VSCALE_BITS;
	localparam int VEL_SHIFT = 8;
	localparam logic [PSUM_BITS-1:0] POS_ROUND = PSUM_BITS'(1) << (POS_SHIFT - 1);
	localparam logic [VSUM_BITS-1:0] VEL_ROUND = VSUM_BITS'(1) << (VEL_SHIFT - 1);

	// stage 3 inputs
	logic                    acc_neg;
	logic [ACC_MAX_BITS-1:0] amag;
	logic                    spd_neg;
	logic [SPEED_BITS-1:0]   smag;

	logic                    valid_s3;
	logic                    motor_s3;
	logic                    pneg_s3;
	logic                    vneg_s3;
	logic [63:0]             pp00_s3;
	logic [47:0]             pp01_s3;
	logic [47:0]             pp10_s3;
	logic [31:0]             pp11_s3;
	logic [VSUM_BITS-1:0]    vprod_s3;

	// output stage inputs
	logic [PSUM_BITS-1:0]           psum;
	logic [PSUM_BITS-POS_SHIFT-1:0] pmag;
	logic                           psat;
	logic                           pneg;
	logic [POS_BITS-1:0]            pos_val;
	logic [VSUM_BITS-1:0]           vsum;
	logic [VSUM_BITS-VEL_SHIFT-1:0] vmag;
	logic                           vsat;
	logic                           vneg;
	logic [VEL_BITS-1:0]            vel_val;
	logic                           ready_o;

	assign acc_neg = sample_s2.acc[ACC_MAX_BITS-1];
	assign amag    = acc_neg ? (~sample_s2.acc + 1'b1) : sample_s2.acc;
	assign spd_neg = sample_s2.speed[SPEED_BITS-1];
	assign smag    = spd_neg ? (~sample_s2.speed + 1'b1) : sample_s2.speed;

	assign ready_o  = !out_valid || out_ready;
	assign ready_s3 = !valid_s3 || ready_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	// Split the wide position product into four partial products.
	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			motor_s3 <= sample_s2.motor;
			pneg_s3  <= acc_neg ^ sample_s2.rev;
			vneg_s3  <= spd_neg ^ sample_s2.rev;
			pp00_s3  <= 64'(amag[31:0]) * 64'(pos_scale[31:0]);
			pp01_s3  <= 48'(amag[31:0]) * 48'(pos_scale[47:32]);
			pp10_s3  <= 48'(amag[47:32]) * 48'(pos_scale[31:0]);
			pp11_s3  <= 32'(amag[47:32]) * 32'(pos_scale[47:32]);
			vprod_s3 <= VSUM_BITS'(smag) * VSUM_BITS'(vel_scale);
		end
	end

	always_comb begin
		psum = {32'b0, pp00_s3} + {16'b0, pp01_s3, 32'b0} + {16'b0, pp10_s3, 32'b0}
			+ {pp11_s3, 64'b0} + POS_ROUND;
		pmag = psum[PSUM_BITS-1:POS_SHIFT];
		psat = |pmag[PSUM_BITS-POS_SHIFT-1:POS_BITS-1];
		pneg = pneg_s3 && (|pmag);
		if (psat) begin
			pos_val = pneg ? POS_MIN : POS_MAX;
		end else begin
			pos_val = pneg ? (~pmag[POS_BITS-1:0] + 1'b1) : pmag[POS_BITS-1:0];
		end

		vsum = vprod_s3 + VEL_ROUND;
		vmag = vsum[VSUM_BITS-1:VEL_SHIFT];
		vsat = |vmag[VSUM_BITS-VEL_SHIFT-1:VEL_BITS-1];
		vneg = vneg_s3 && (|vmag);
		if (vsat) begin
			vel_val = vneg ? VEL_MIN : VEL_MAX;
		end else begin
			vel_val = vneg ? (~vmag[VEL_BITS-1:0] + 1'b1) : vmag[VEL_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_o) begin
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && ready_o) begin
			out_motor <= motor_s3;
			out_data  <= {pos_val, vel_val};
		end
	end

	a_s3_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ready_s3) |=> valid_s3)
		else $error("scaler dropped a tracked sample");

	a_out_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && ready_o) |=> out_valid)
		else $error("scaled word did not reach the output register");

endmodule

/* hw/rtl/motor_feedback_frame_unwrap_top.sv */
// Top level of the motor feedback frame decoder with multiturn unwrap.
`timescale 1ns / 1ps
// Usage:
//   The slave stream carries one word per received feedback frame, or a
//   restart word (tuser bit 0 set) that clears the tracking of all motors.
//   A frame whose identifier, length and reply code match the motor's
//   settings updates that motor's unwrapped encoder count and yields one
//   word on the master stream: joint velocity (Q15.16) and joint position
//   (Q31.16), both saturated, with the motor number in tuser. Rejected
//   frames and restart words yield nothing.
//   Path: a result word passes the input register, tracker register,
//   partial-product register and output register in turn after its frame
//   word is accepted. Throughput: one word per cycle unless the master
//   side stalls.
//   Settings are written through the APB port while the stream is idle;
//   pready is always high.
//   Reset: settings return to their defaults, tracking is cleared and any
//   word in flight is dropped.
//   Stall: when the master side stalls, each stage holds its word; the
//   slave side keeps accepting until every stage is full.
module motor_feedback_frame_unwrap_top
	import mffu_pkg::*;
#(
	parameter int MOTOR_COUNT  = MOTOR_COUNT_DEF,
	parameter int ENCODER_BITS = ENCODER_BITS_DEF,
	parameter int ACCUM_BITS   = ACCUM_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// slave stream
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// frame_id[10:0], frame_length[14:11], reply_code[22:15], speed_low[30:23],
	// speed_high[38:31], encoder_low[46:39], encoder_high[54:47], zero[55]
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	// kind[0], motor_sel[1]
	input  logic [IN_USER_BITS-1:0]  s_axis_tuser,
	// master stream
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// joint_velocity[31:0], joint_position[79:32]
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	// motor_number[0]
	output logic [0:0]               m_axis_tuser,
	// configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	// Settings registers.
	logic [ID_BITS-1:0]     left_id_q;
	logic [ID_BITS-1:0]     right_id_q;
	logic                   left_rev_q;
	logic                   right_rev_q;
	logic [PSCALE_BITS-1:0] pos_scale_q;
	logic [VSCALE_BITS-1:0] vel_scale_q;

	reg_idx_t    reg_idx;
	logic        cfg_wr;
	mffu_match_t match;

	// Input register.
	logic         valid_s1;
	mffu_item_t   item_s1;
	logic         ready_s1;
	logic         ready_s2;
	logic         valid_s2;
	logic         ready_s3;
	logic         take;
	mffu_sample_t sample_s2;

	// Registers sit at 8-byte spacing; the low address bits are ignored.
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:3]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_id_q   <= '0;
			right_id_q  <= '0;
			left_rev_q  <= 1'b0;
			right_rev_q <= 1'b0;
			pos_scale_q <= POS_SCALE_RST;
			vel_scale_q <= VEL_SCALE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LEFT_ID:   left_id_q   <= pwdata[ID_BITS-1:0];
				REG_RIGHT_ID:  right_id_q  <= pwdata[ID_BITS-1:0];
				REG_LEFT_REV:  left_rev_q  <= pwdata[0];
				REG_RIGHT_REV: right_rev_q <= pwdata[0];
				REG_POS_SCALE: pos_scale_q <= pwdata[PSCALE_BITS-1:0];
				REG_VEL_SCALE: vel_scale_q <= pwdata[VSCALE_BITS-1:0];
				default: ; // drop writes to unused addresses
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LEFT_ID:   prdata = APB_DATA_BITS'(left_id_q);
			REG_RIGHT_ID:  prdata = APB_DATA_BITS'(right_id_q);
			REG_LEFT_REV:  prdata = APB_DATA_BITS'(left_rev_q);
			REG_RIGHT_REV: prdata = APB_DATA_BITS'(right_rev_q);
			REG_POS_SCALE: prdata = APB_DATA_BITS'(pos_scale_q);
			REG_VEL_SCALE: prdata = APB_DATA_BITS'(vel_scale_q);
			default:       prdata = '0;
		endcase
	end

	assign match.left_id   = left_id_q;
	assign match.right_id  = right_id_q;
	assign match.left_rev  = left_rev_q;
	assign match.right_rev = right_rev_q;

	// Take a new word whenever the input register is empty or moves on.
	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;
	assign take          = valid_s1 && ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && ready_s1) begin
			item_s1.kind         <= item_kind_t'(s_axis_tuser[0]);
			item_s1.motor        <= s_axis_tuser[1];
			item_s1.frame_id     <= s_axis_tdata[10:0];
			item_s1.frame_length <= s_axis_tdata[14:11];
			item_s1.reply_code   <= s_axis_tdata[22:15];
			item_s1.speed        <= {s_axis_tdata[38:31], s_axis_tdata[30:23]};
			item_s1.encoder      <= {s_axis_tdata[54:47], s_axis_tdata[46:39]};
		end
	end

	// Filter the frame and advance the motor's unwrapped count.
	mffu_track #(
		.MOTOR_COUNT  (MOTOR_COUNT),
		.ENCODER_BITS (ENCODER_BITS),
		.ACCUM_BITS   (ACCUM_BITS)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item_s1),
		.match     (match),
		.ready_s3  (ready_s3),
		.ready_s2  (ready_s2),
		.valid_s2  (valid_s2),
		.sample_s2 (sample_s2)
	);

	// Scale, round and saturate, then hold the result for the master side.
	mffu_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.sample_s2 (sample_s2),
		.pos_scale (pos_scale_q),
		.vel_scale (vel_scale_q),
		.ready_s3  (ready_s3),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_motor (m_axis_tuser[0]),
		.out_data  (m_axis_tdata)
	);

	a_in_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted word missing from input register");

	a_vel_scale_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_idx == REG_VEL_SCALE) |=> vel_scale_q == $past(pwdata[VSCALE_BITS-1:0]))
		else $error("velocity scale write lost");

endmodule

/* bench/motor_feedback_frame_unwrap_top_tb.sv */
// Self-checking bench for the motor feedback frame unwrap block.
`timescale 1ns / 1ps
module motor_feedback_frame_unwrap_top_tb;
	import mffu_pkg::*;

	localparam int     ENC_W      = ENCODER_BITS_DEF;
	localparam longint TURN_FULL  = longint'(1) << ENC_W;
	localparam longint TURN_HALF  = TURN_FULL / 2;
	localparam longint TURNS_HI   = (longint'(1) << (ACCUM_BITS_DEF - 1)) - 1;
	localparam longint TURNS_LO   = -TURNS_HI - 1;
	localparam int     CYCLE_CAP  = 500000;
	localparam int     RX_HOLD    = 300;
	localparam int     SETTLE_CYC = 8;

	// Tracks per-motor unwrap state and the joint readings still owed by the block.
	class joint_reading_board;
		typedef struct {
			bit                  motor;
			logic [VEL_BITS-1:0] velocity;
			logic [POS_BITS-1:0] position;
		} reading_t;

		logic [ID_BITS-1:0]     frame_id [2];
		bit                     reverse [2];
		logic [PSCALE_BITS-1:0] pos_scale;
		logic [VSCALE_BITS-1:0] vel_scale;
		bit                     seeded [2];
		logic [ENC_W-1:0]       last_count [2];
		longint                 turns [2];
		reading_t               awaited [$];
		int mismatches, words, restarts, readings, vel_clips, pos_clips;

		function new();
			frame_id[0] = '0;
			frame_id[1] = '0;
			reverse[0]  = 1'b0;
			reverse[1]  = 1'b0;
			pos_scale   = POS_SCALE_RST;
			vel_scale   = VEL_SCALE_RST;
			clear_tracking();
		endfunction

		function void clear_tracking();
			foreach (seeded[m]) begin
				seeded[m]     = 1'b0;
				last_count[m] = '0;
				turns[m]      = 0;
			end
		endfunction

		// Store a setting and return the value the register should read back.
		function logic [63:0] set_register(reg_idx_t r, logic [63:0] v);
			case (r)
				REG_LEFT_ID: begin
					frame_id[0] = v[ID_BITS-1:0];
					return 64'(frame_id[0]);
				end
				REG_RIGHT_ID: begin
					frame_id[1] = v[ID_BITS-1:0];
					return 64'(frame_id[1]);
				end
				REG_LEFT_REV: begin
					reverse[0] = v[0];
					return 64'(reverse[0]);
				end
				REG_RIGHT_REV: begin
					reverse[1] = v[0];
					return 64'(reverse[1]);
				end
				REG_POS_SCALE: begin
					pos_scale = v[PSCALE_BITS-1:0];
					return 64'(pos_scale);
				end
				default: begin
					vel_scale = v[VSCALE_BITS-1:0];
					return 64'(vel_scale);
				end
			endcase
		endfunction

		function void mismatch(string what, logic [79:0] exp_v, logic [79:0] act_v);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %h, got %h", what, exp_v, act_v);
		endfunction

		// Apply sign to a magnitude and clip to a signed range of the given width.
		function logic [63:0] clamp_signed(logic [127:0] mag, bit neg, int bits);
			logic [127:0] lim;
			lim = 128'd1 << (bits - 1);
			if (neg)
				return (mag >= lim) ? 64'(-lim) : 64'(-mag);
			return (mag >= lim) ? 64'(lim - 128'd1) : 64'(mag);
		endfunction

		// Predict the reading caused by one accepted word, if any.
		function void note_frame(mffu_item_t it);
			logic [ENC_W-1:0] count;
			longint           delta, nxt;
			logic [16:0]      smag;
			logic [127:0]     vmag, amag, pmag;
			bit               vneg, pneg, m;
			reading_t         rd;
			words++;
			if (it.kind == KIND_RESTART) begin
				restarts++;
				clear_tracking();
				return;
			end
			m = it.motor;
			if (it.frame_id != frame_id[m] || it.frame_length < MIN_LENGTH ||
					it.reply_code != REPLY_STATUS)
				return;
			count = it.encoder[ENC_W-1:0];
			if (!seeded[m]) begin
				nxt       = longint'(count);
				seeded[m] = 1'b1;
			end else begin
				delta = longint'(count) - longint'(last_count[m]);
				if (delta > TURN_HALF)
					delta -= TURN_FULL;
				else if (delta < -TURN_HALF)
					delta += TURN_FULL;
				nxt = turns[m] + delta;
				if (nxt > TURNS_HI)
					nxt = TURNS_HI;
				if (nxt < TURNS_LO)
					nxt = TURNS_LO;
			end
			turns[m]      = nxt;
			last_count[m] = count;

			vneg = it.speed[SPEED_BITS-1];
			smag = vneg ? 17'h10000 - 17'(it.speed) : 17'(it.speed);
			vmag = (128'(smag) * 128'(vel_scale) + 128'd128) >> 8;
			vneg = vneg ^ reverse[m];

			amag = (nxt < 0) ? 128'(-nxt) : 128'(nxt);
			pmag = (amag * 128'(pos_scale) + (128'd1 << 23)) >> 24;
			pneg = (nxt < 0) ^ reverse[m];

			if (vmag >= (128'd1 << (VEL_BITS - 1)))
				vel_clips++;
			if (pmag >= (128'd1 << (POS_BITS - 1)))
				pos_clips++;
			rd.motor    = m;
			rd.velocity = VEL_BITS'(clamp_signed(vmag, vneg, VEL_BITS));
			rd.position = POS_BITS'(clamp_signed(pmag, pneg, POS_BITS));
			awaited.push_back(rd);
		endfunction

		function void check_reading(bit motor, logic [VEL_BITS-1:0] vel,
				logic [POS_BITS-1:0] pos);
			reading_t e;
			if (awaited.size() == 0) begin
				mismatch("unexpected output word", 80'(0), {pos, vel});
				return;
			end
			e = awaited.pop_front();
			readings++;
			if (motor !== e.motor)
				mismatch("motor_number", 80'(e.motor), 80'(motor));
			if (vel !== e.velocity)
				mismatch("joint_velocity", 80'(e.velocity), 80'(vel));
			if (pos !== e.position)
				mismatch("joint_position", 80'(e.position), 80'(pos));
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	// frame_id[10:0], frame_length[14:11], reply_code[22:15], speed_low[30:23],
	// speed_high[38:31], encoder_low[46:39], encoder_high[54:47], zero[55]
	logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
	// kind[0], motor_sel[1]
	logic [IN_USER_BITS-1:0]  s_axis_tuser  = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	// joint_velocity[31:0], joint_position[79:32]
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;
	// motor_number[0]
	logic [0:0]               m_axis_tuser;
	logic                     psel          = 1'b0;
	logic                     penable       = 1'b0;
	logic                     pwrite        = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr         = '0;
	logic [APB_DATA_BITS-1:0] pwdata        = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	joint_reading_board board = new();

	// Stimulus controls: idle gaps per side, and requests for long output stalls
	// (the output process counts the ones it has served).
	bit               tx_gaps;
	bit               rx_gaps;
	int               hold_req  = 0;
	int               hold_done = 0;
	logic [ENC_W-1:0] trail [2];
	int               cycles    = 0;

	motor_feedback_frame_unwrap_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("motor_feedback_frame_unwrap_top regression: fail");
			$finish;
		end
	end

	// Sample both handshakes at the edge: note each accepted input word first,
	// then check any output word against the oldest owed reading.
	always @(posedge clk) begin
		mffu_item_t it;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				it.kind         = item_kind_t'(s_axis_tuser[0]);
				it.motor        = s_axis_tuser[1];
				it.frame_id     = s_axis_tdata[10:0];
				it.frame_length = s_axis_tdata[14:11];
				it.reply_code   = s_axis_tdata[22:15];
				it.speed        = s_axis_tdata[38:23];
				it.encoder      = s_axis_tdata[54:39];
				board.note_frame(it);
			end
			if (m_axis_tvalid && m_axis_tready)
				board.check_reading(m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[79:32]);
		end
	end

	// Output side: random ready bursts, plus one long stall on request so the
	// pipeline fills and pushes back on the input.
	initial begin
		forever begin
			if (hold_req != hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
				hold_done++;
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	function mffu_item_t frame_word(bit motor, logic [ID_BITS-1:0] id,
			logic [LEN_BITS-1:0] len, logic [BYTE_BITS-1:0] reply,
			logic [SPEED_BITS-1:0] speed, logic [ENC_RAW_BITS-1:0] enc);
		mffu_item_t it;
		it.kind         = KIND_FRAME;
		it.motor        = motor;
		it.frame_id     = id;
		it.frame_length = len;
		it.reply_code   = reply;
		it.speed        = speed;
		it.encoder      = enc;
		return it;
	endfunction

	function mffu_item_t restart_word();
		mffu_item_t it;
		it      = frame_word(1'($urandom), 11'($urandom), 4'($urandom), 8'($urandom),
				16'($urandom), 16'($urandom));
		it.kind = KIND_RESTART;
		return it;
	endfunction

	// Pick the next count for a motor: small moves, half-turn jumps,
	// wraps across zero, or anything at all.
	function logic [ENC_W-1:0] next_count(bit m);
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return trail[m] + ENC_W'($urandom_range(0, 600)) - ENC_W'(300);
		if (r < 65)
			return trail[m] + ENC_W'($urandom_range(8191, 8193));
		if (r < 80)
			return ($urandom_range(0, 1) != 0) ? ENC_W'($urandom_range(0, 40)) :
					ENC_W'(16383 - $urandom_range(0, 40));
		return ENC_W'($urandom);
	endfunction

	function logic [47:0] rand_scale(int bits);
		logic [63:0] v;
		v = {$urandom, $urandom};
		v = v >> (64 - $urandom_range(1, bits));
		return (v == 0) ? 48'd1 : 48'(v);
	endfunction

	// Offer one word, hold it until accepted, then maybe idle.
	task automatic send_word(mffu_item_t it);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, it.encoder, it.speed, it.reply_code, it.frame_length,
				it.frame_id};
		s_axis_tuser  <= {it.motor, it.kind};
		do @(posedge clk); while (!s_axis_tready);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic send_good(bit m, logic [ENC_W-1:0] count);
		trail[m] = count;
		send_word(frame_word(m, board.frame_id[m], 4'($urandom_range(8, 15)), REPLY_STATUS,
				16'($urandom), {2'($urandom), count}));
	endtask

	// Break exactly one of the match conditions.
	task automatic send_broken();
		mffu_item_t it;
		bit         m;
		m  = 1'($urandom);
		it = frame_word(m, board.frame_id[m], 4'($urandom_range(8, 15)), REPLY_STATUS,
				16'($urandom), 16'($urandom));
		case ($urandom_range(0, 2))
			0: it.frame_id = it.frame_id ^ (ID_BITS'(1) << $urandom_range(0, 10));
			1: it.frame_length = 4'($urandom_range(0, 7));
			default: it.reply_code = it.reply_code ^ 8'($urandom_range(1, 255));
		endcase
		send_word(it);
	endtask

	task automatic run_mixed(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 72)
				send_good(1'(r), next_count(1'(r)));
			else if (r < 87)
				send_broken();
			else if (r < 95)
				send_word(frame_word(1'($urandom), 11'($urandom), 4'($urandom), 8'($urandom),
						16'($urandom), 16'($urandom)));
			else
				send_word(restart_word());
		end
	endtask

	// Drop valid, wait for every owed reading, then let stray words drain.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Write one register, read it back and compare.
	task automatic write_setting(reg_idx_t r, logic [63:0] v);
		logic [63:0] want, got;
		want = board.set_register(r, v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 3'b000};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== want)
			board.mismatch("register readback", 80'(want), 80'(got));
	endtask

	task automatic apply_settings(logic [ID_BITS-1:0] lid, logic [ID_BITS-1:0] rid,
			bit lrev, bit rrev, logic [PSCALE_BITS-1:0] ps, logic [VSCALE_BITS-1:0] vs);
		write_setting(REG_LEFT_ID, 64'(lid));
		write_setting(REG_RIGHT_ID, 64'(rid));
		write_setting(REG_LEFT_REV, 64'(lrev));
		write_setting(REG_RIGHT_REV, 64'(rrev));
		write_setting(REG_POS_SCALE, 64'(ps));
		write_setting(REG_VEL_SCALE, 64'(vs));
	endtask

	initial begin
		int r;
		tx_gaps  = 1'b1;
		rx_gaps  = 1'b1;
		trail[0] = '0;
		trail[1] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under reset settings: speed extremes, seed, wrap by one,
		// half-turn deltas kept as is, deltas just past half a turn folded back,
		// each rejection cause, ignored top encoder bits, and restart reseeding.
		send_word(frame_word(1'b0, 11'h000, 4'd8, REPLY_STATUS, 16'h7FFF, 16'h0000));
		send_word(frame_word(1'b0, 11'h000, 4'd15, REPLY_STATUS, 16'h8000, 16'hFFFF));
		send_word(frame_word(1'b0, 11'h000, 4'd8, REPLY_STATUS, 16'hFFFF, 16'h1FFF));
		send_word(frame_word(1'b0, 11'h000, 4'd8, REPLY_STATUS, 16'h0001, 16'h3FFF));
		send_word(frame_word(1'b0, 11'h000, 4'd8, REPLY_STATUS, 16'h0000, 16'h1FFE));
		send_word(frame_word(1'b0, 11'h000, 4'd9, REPLY_STATUS, 16'h0080, 16'h3FFF));
		send_word(frame_word(1'b0, 11'h000, 4'd7, REPLY_STATUS, 16'h1111, 16'h0100));
		send_word(frame_word(1'b0, 11'h000, 4'd0, REPLY_STATUS, 16'h1111, 16'h0100));
		send_word(frame_word(1'b0, 11'h000, 4'd8, 8'h9D, 16'h2222, 16'h0200));
		send_word(frame_word(1'b0, 11'h000, 4'd8, 8'hFF, 16'h2222, 16'h0200));
		send_word(frame_word(1'b0, 11'h000, 4'd8, 8'h00, 16'h2222, 16'h0200));
		send_word(frame_word(1'b0, 11'h001, 4'd8, REPLY_STATUS, 16'h3333, 16'h0300));
		send_word(frame_word(1'b1, 11'h000, 4'd8, REPLY_STATUS, 16'h8001, 16'hC000));
		send_word(frame_word(1'b1, 11'h000, 4'd8, REPLY_STATUS, 16'h00FF, 16'h2000));
		send_word(frame_word(1'b1, 11'h7FF, 4'd8, REPLY_STATUS, 16'h00FF, 16'h2000));
		send_word(restart_word());
		send_word(frame_word(1'b0, 11'h000, 4'd8, REPLY_STATUS, 16'h1234, 16'h6ABC));
		send_word(frame_word(1'b1, 11'h000, 4'd12, REPLY_STATUS, 16'hFF00, 16'h8005));
		send_word(frame_word(1'b1, 11'h000, 4'd8, REPLY_STATUS, 16'h4000, 16'h0007));
		settle();

		// Largest scales and extreme ids; open with a long output stall while
		// the input keeps offering back to back.
		apply_settings(11'h7FF, 11'h000, 1'b1, 1'b0, '1, '1);
		tx_gaps = 1'b0;
		hold_req++;
		run_mixed(40);
		tx_gaps = 1'b1;
		run_mixed(100);
		settle();

		// Zero scales give zero readings.
		apply_settings(11'h2AA, 11'h555, 1'b0, 1'b1, '0, '0);
		run_mixed(80);
		settle();

		// Smallest nonzero scales.
		apply_settings(11'($urandom), 11'($urandom), 1'b1, 1'b1, 48'd1, 32'd1);
		run_mixed(80);
		settle();

		// Spin the left motor forward by just under half a turn per frame until
		// the position clips at the largest scale; reversed, so it clips low.
		apply_settings(11'($urandom), 11'($urandom), 1'b1, 1'($urandom), '1,
				32'(rand_scale(VSCALE_BITS)));
		send_word(restart_word());
		for (int i = 0; i < 1150; i++) begin
			r = $urandom_range(0, 99);
			if (r < 95)
				send_good(1'b0, trail[0] + ENC_W'($urandom_range(8188, 8191)));
			else if (r < 98)
				send_broken();
			else
				send_good(1'b1, next_count(1'b1));
		end
		settle();

		apply_settings(11'($urandom), 11'($urandom), 1'($urandom), 1'($urandom),
				rand_scale(PSCALE_BITS), 32'(rand_scale(VSCALE_BITS)));
		run_mixed(80);
		settle();

		// Last stretch at full rate on both sides.
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		apply_settings(11'($urandom), 11'($urandom), 1'($urandom), 1'($urandom),
				rand_scale(PSCALE_BITS), 32'(rand_scale(VSCALE_BITS)));
		run_mixed(80);
		settle();

		if (board.pending() != 0)
			board.mismatch("readings never delivered", 80'(board.pending()), 80'(0));
		$display("sent %0d words including %0d restarts across seven register setups; %0s %0d",
				board.words, board.restarts, "checked readings:", board.readings);
		$display("velocity clipped in %0d readings, position in %0d; %0d mismatches",
				board.vel_clips, board.pos_clips, board.mismatches);
		if (board.mismatches == 0)
			$display("motor_feedback_frame_unwrap_top regression: pass");
		else
			$display("motor_feedback_frame_unwrap_top regression: fail");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/mffu_pkg.sv
hw/rtl/mffu_track.sv
hw/rtl/mffu_scale.sv
hw/rtl/motor_feedback_frame_unwrap_top.sv
bench/motor_feedback_frame_unwrap_top_tb.sv
